FILE: hdl/sff_pkg.sv
// shared types, constants and codes for the stribeck friction force pipeline
// no dependencies
package sff_pkg;

  localparam int DEF_COEFF_FRAC_BITS = 14;
  localparam int DEF_SPEED_FRAC_BITS = 16;

  localparam int NUM_W  = 33;
  localparam int DEN_W  = 17;
  localparam int QUOT_W = 17;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  localparam logic [31:0] RST_TRANSITION = 32'd655;
  localparam logic [31:0] RST_INVERSE    = 32'd6553600;
  localparam logic [31:0] RST_THRESHOLD  = 32'd1;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_THREE = 64'h0000_0003_0000_0000;
  localparam logic [63:0] Q_FOUR  = 64'h0000_0004_0000_0000;

  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_STICTION,
    SEG_STRIBECK,
    SEG_TRANSITION,
    SEG_SLIDING
  } seg_t;

  typedef struct packed {
    logic [15:0] static_first;
    logic [15:0] static_second;
    logic [15:0] dynamic_first;
    logic [15:0] dynamic_second;
    logic [15:0] viscous_first;
    logic [15:0] viscous_second;
    logic [31:0] slip_speed;
    logic signed [31:0] normal_force;
  } item_t;

  typedef struct packed {
    logic [23:0] friction_coeff;
    logic [30:0] friction_force;
    logic [43:0] friction_power;
    logic [2:0]  segment;
  } result_t;

  typedef struct packed {
    seg_t        seg;
    logic [63:0] x;
    logic [63:0] fa;
    logic [63:0] level;
    logic        sub;
    logic [63:0] poly;
    logic [30:0] nraw;
    logic [31:0] slip;
    logic        kill;
  } curve_tag_t;

endpackage

FILE: hdl/sff_hdiv.sv
// pipelined restoring divider for the harmonic combination 2ab/(a+b)
// one quotient bit per stage; depends on sff_pkg
module sff_hdiv import sff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              out_vld,
  output logic [QUOT_W-1:0] quot
);

  logic              vld_s [1:QUOT_W];
  logic [DEN_W-1:0]  rem_s [1:QUOT_W];
  logic [NUM_W-1:0]  num_s [1:QUOT_W];
  logic [DEN_W-1:0]  den_s [1:QUOT_W];
  logic [QUOT_W-1:0] q_s   [1:QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic              vld_i;
    logic [DEN_W-1:0]  rem_i;
    logic [NUM_W-1:0]  num_i;
    logic [DEN_W-1:0]  den_i;
    logic [QUOT_W-1:0] q_i;
    logic [QUOT_W-1:0] q_o;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = DEN_W'(num[NUM_W-1:QUOT_W]);
      assign num_i = num;
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign vld_i = vld_s[k];
      assign rem_i = rem_s[k];
      assign num_i = num_s[k];
      assign den_i = den_s[k];
      assign q_i   = q_s[k];
    end

    assign trial = {rem_i, num_i[QUOT_W-1-k]};
    assign fits  = (trial >= {1'b0, den_i});

    always_comb begin
      q_o = q_i;
      q_o[QUOT_W-1-k] = fits;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_i;
      end
      rem_s[k+1] <= fits ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
      num_s[k+1] <= num_i;
      den_s[k+1] <= den_i;
      q_s[k+1]   <= q_o;
    end
  end

  assign out_vld = vld_s[QUOT_W];
  assign quot    = q_s[QUOT_W];

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (rem_s[QUOT_W] < den_s[QUOT_W]))
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/sff_mulq.sv
// two-stage 64x64 fixed-point multiply, 32 fraction bits, saturating
// four 32x32 partial products then one sum; depends on sff_pkg
module sff_mulq import sff_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [63:0]      prod,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld_a;
  logic [63:0]      hh;
  logic [63:0]      hl;
  logic [63:0]      lh;
  logic [63:0]      ll;
  logic [TAG_W-1:0] tag_a;
  logic [65:0]      sum;
  logic             sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= in_vld;
    end
    hh    <= a[63:32] * b[63:32];
    hl    <= a[63:32] * b[31:0];
    lh    <= a[31:0] * b[63:32];
    ll    <= a[31:0] * b[31:0];
    tag_a <= in_tag;
  end

  assign sum = {2'b00, hh[31:0], 32'h0} + {2'b00, hl} + {2'b00, lh} + {34'h0, ll[63:32]};
  assign sat = (|hh[63:32]) || (|sum[65:64]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_a;
    end
    prod    <= sat ? '1 : sum[63:0];
    out_tag <= tag_a;
  end

endmodule

FILE: hdl/sff_curve.sv
// quintic stribeck curve: x^2, x^3 with blend polynomial, step, scale, level add
// chain of sff_mulq stages; depends on sff_pkg and sff_mulq
module sff_curve import sff_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  curve_tag_t in_tag,
  output logic       out_vld,
  output curve_tag_t out_tag
);

  localparam int TAG_W = $bits(curve_tag_t);

  logic        vld1, vld2, vld3, vld4;
  logic [63:0] x2, x3, t, m;
  curve_tag_t  tag1, tag1p, tag2, tag3, tag4;
  logic [63:0] poly;
  logic [63:0] scale_b;
  logic [64:0] wide_sum;

  sff_mulq #(.TAG_W(TAG_W)) u_sq (
    .clk(clk), .rst(rst), .in_vld(in_vld), .a(in_tag.x), .b(in_tag.x),
    .in_tag(in_tag), .out_vld(vld1), .prod(x2), .out_tag(tag1)
  );

  always_comb begin
    if (tag1.seg == SEG_TRANSITION) begin
      poly = 64'd6 * Q_ONE + 64'd3 * x2 - 64'd8 * tag1.x;
    end else begin
      poly = 64'd10 * Q_ONE + 64'd6 * x2 - 64'd15 * tag1.x;
    end
    tag1p      = tag1;
    tag1p.poly = poly;
  end

  sff_mulq #(.TAG_W(TAG_W)) u_cube (
    .clk(clk), .rst(rst), .in_vld(vld1), .a(x2), .b(tag1.x),
    .in_tag(tag1p), .out_vld(vld2), .prod(x3), .out_tag(tag2)
  );

  sff_mulq #(.TAG_W(TAG_W)) u_blend (
    .clk(clk), .rst(rst), .in_vld(vld2), .a(x3), .b(tag2.poly),
    .in_tag(tag2), .out_vld(vld3), .prod(t), .out_tag(tag3)
  );

  assign scale_b = (tag3.seg == SEG_SLIDING) ? tag3.x : t;

  sff_mulq #(.TAG_W(TAG_W)) u_scale (
    .clk(clk), .rst(rst), .in_vld(vld3), .a(tag3.fa), .b(scale_b),
    .in_tag(tag3), .out_vld(vld4), .prod(m), .out_tag(tag4)
  );

  assign wide_sum = {1'b0, tag4.level} + {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld4;
    end
    out_tag <= tag4;
    case (tag4.seg)
      SEG_STICTION: begin
        out_tag.level <= m;
      end
      SEG_STRIBECK: begin
        out_tag.level <= tag4.sub ? tag4.level - m : tag4.level + m;
      end
      default: begin
        out_tag.level <= wide_sum[64] ? '1 : wide_sum[63:0];
      end
    endcase
  end

endmodule

FILE: hdl/stribeck_friction_force_top.sv
// top level of the stribeck friction force pipeline: ports, config registers,
// operand stages, dividers, curve and force/power stages; uses all sff files
//
// usage:
//   one contact transaction is accepted at a rising edge with start high and
//   busy low; busy is high only during reset, so a new contact may enter on
//   every cycle
//   each result appears on result for exactly one cycle with done high;
//   results leave in entry order
//   the path runs through the 17-stage harmonic-mean dividers and the
//   chain of five two-stage fixed-point multipliers
//   throughput: one contact per cycle
//   the receiver cannot stall, so the pipeline never holds
//   config: registers written with cfg_write, cfg_index, cfg_data; write only
//   while no contact is in flight; index 3 is ignored
//   reset: synchronous, clears the pipeline valid bits and loads the
//   register defaults
module stribeck_friction_force_top import sff_pkg::*; #(
  parameter int COEFF_FRAC_BITS = DEF_COEFF_FRAC_BITS,
  parameter int SPEED_FRAC_BITS = DEF_SPEED_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int US_SH   = 32 - COEFF_FRAC_BITS;
  localparam int UV_SUM  = COEFF_FRAC_BITS + SPEED_FRAC_BITS;
  localparam int UV_RSH  = (UV_SUM >= 32) ? UV_SUM - 32 : 0;
  localparam int UV_LSH  = (UV_SUM >= 32) ? 0 : 32 - UV_SUM;
  localparam int V_RSH   = (2 * SPEED_FRAC_BITS >= 32) ? 2 * SPEED_FRAC_BITS - 32 : 0;
  localparam int V_LSH   = (2 * SPEED_FRAC_BITS >= 32) ? 0 : 32 - 2 * SPEED_FRAC_BITS;
  localparam int TAG_W   = $bits(curve_tag_t);

  typedef struct packed {
    logic [63:0] vprod;
    logic [30:0] nraw;
    logic [31:0] slip;
    logic        kill;
  } side_t;

  logic [31:0] transition_velocity;
  logic [31:0] inverse_transition;
  logic [31:0] slip_threshold;

  // operand stage
  logic              vld1;
  logic [NUM_W-1:0]  num1 [0:2];
  logic [DEN_W-1:0]  den1 [0:2];
  side_t             side1;
  logic [31:0]       prod_s, prod_d, prod_v;

  // divider stages
  logic              dvld [0:2];
  logic [QUOT_W-1:0] quot [0:2];
  side_t             side_d [1:QUOT_W];

  // scaling stage
  logic              vld2;
  logic [63:0]       us2, ud2, v2;
  logic [48:0]       uvprod2;
  logic [30:0]       nraw2;
  logic [31:0]       slip2;
  logic              kill2;
  logic [63:0]       v_calc;

  // segment stage
  logic              vld3;
  curve_tag_t        tag3;
  curve_tag_t        tag3_next;
  logic [63:0]       uvs;
  logic [63:0]       diff;

  // curve and force
  logic              cvld;
  curve_tag_t        ctag;
  logic              fvld;
  logic [63:0]       force_raw;
  curve_tag_t        ftag;

  // power stage
  logic              vld_p;
  logic [30:0]       force_p;
  logic [62:0]       pprod;
  logic [23:0]       coeff_p;
  seg_t              seg_p;
  logic              kill_p;
  logic [62:0]       power_sh;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_velocity <= RST_TRANSITION;
      inverse_transition  <= RST_INVERSE;
      slip_threshold      <= RST_THRESHOLD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRANSITION: transition_velocity <= cfg_data;
        REG_INVERSE:    inverse_transition  <= cfg_data;
        REG_THRESHOLD:  slip_threshold      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prod_s = item.static_first * item.static_second;
  assign prod_d = item.dynamic_first * item.dynamic_second;
  assign prod_v = item.viscous_first * item.viscous_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start && !busy;
    end
    num1[0] <= {prod_s, 1'b0};
    num1[1] <= {prod_d, 1'b0};
    num1[2] <= {prod_v, 1'b0};
    den1[0] <= (prod_s == 32'h0) ? DEN_W'(1)
             : {1'b0, item.static_first} + {1'b0, item.static_second};
    den1[1] <= (prod_d == 32'h0) ? DEN_W'(1)
             : {1'b0, item.dynamic_first} + {1'b0, item.dynamic_second};
    den1[2] <= (prod_v == 32'h0) ? DEN_W'(1)
             : {1'b0, item.viscous_first} + {1'b0, item.viscous_second};
    side1.vprod <= item.slip_speed * inverse_transition;
    side1.nraw  <= item.normal_force[30:0];
    side1.slip  <= item.slip_speed;
    side1.kill  <= (item.normal_force <= 32'sd0) || (item.slip_speed <= slip_threshold);
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    sff_hdiv u_div (
      .clk(clk), .rst(rst), .in_vld(vld1), .num(num1[i]), .den(den1[i]),
      .out_vld(dvld[i]), .quot(quot[i])
    );
  end

  for (genvar j = 1; j <= QUOT_W; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (j == 1) begin
        side_d[j] <= side1;
      end else begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  always_comb begin
    if (2 * SPEED_FRAC_BITS >= 32) begin
      v_calc = side_d[QUOT_W].vprod >> V_RSH;
    end else if ((side_d[QUOT_W].vprod >> (64 - V_LSH)) != 64'h0) begin
      v_calc = '1;
    end else begin
      v_calc = side_d[QUOT_W].vprod << V_LSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= dvld[0];
    end
    us2     <= 64'(quot[0]) << US_SH;
    ud2     <= 64'(quot[1]) << US_SH;
    uvprod2 <= quot[2] * transition_velocity;
    v2      <= v_calc;
    nraw2   <= side_d[QUOT_W].nraw;
    slip2   <= side_d[QUOT_W].slip;
    kill2   <= side_d[QUOT_W].kill;
  end

  assign uvs  = (UV_SUM >= 32) ? (64'(uvprod2) >> UV_RSH) : (64'(uvprod2) << UV_LSH);
  assign diff = (us2 >= ud2) ? us2 - ud2 : ud2 - us2;

  always_comb begin
    tag3_next       = '0;
    tag3_next.nraw  = nraw2;
    tag3_next.slip  = slip2;
    tag3_next.kill  = kill2;
    tag3_next.sub   = (us2 >= ud2);
    if (v2 <= Q_ONE) begin
      tag3_next.seg   = SEG_STICTION;
      tag3_next.x     = v2;
      tag3_next.fa    = us2;
      tag3_next.level = 64'h0;
    end else if (v2 <= Q_THREE) begin
      tag3_next.seg   = SEG_STRIBECK;
      tag3_next.x     = (v2 - Q_ONE) >> 1;
      tag3_next.fa    = diff;
      tag3_next.level = us2;
    end else if (v2 <= Q_FOUR) begin
      tag3_next.seg   = SEG_TRANSITION;
      tag3_next.x     = v2 - Q_THREE;
      tag3_next.fa    = uvs;
      tag3_next.level = ud2;
    end else begin
      tag3_next.seg   = SEG_SLIDING;
      tag3_next.x     = v2 - Q_THREE;
      tag3_next.fa    = uvs;
      tag3_next.level = ud2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    tag3 <= tag3_next;
  end

  sff_curve u_curve (
    .clk(clk), .rst(rst), .in_vld(vld3), .in_tag(tag3),
    .out_vld(cvld), .out_tag(ctag)
  );

  sff_mulq #(.TAG_W(TAG_W)) u_force (
    .clk(clk), .rst(rst), .in_vld(cvld), .a(64'(ctag.nraw)), .b(ctag.level),
    .in_tag(ctag), .out_vld(fvld), .prod(force_raw), .out_tag(ftag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else begin
      vld_p <= fvld;
    end
    force_p <= (force_raw > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : force_raw[30:0];
    pprod   <= ((force_raw > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : force_raw[30:0]) * ftag.slip;
    coeff_p <= (|ftag.level[63:40]) ? 24'hFF_FFFF : ftag.level[39:16];
    seg_p   <= ftag.seg;
    kill_p  <= ftag.kill;
  end

  assign power_sh = pprod >> SPEED_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_p;
    end
    if (kill_p) begin
      result <= '0;
    end else begin
      result.friction_coeff <= coeff_p;
      result.friction_force <= force_p;
      result.friction_power <= (|power_sh[62:44]) ? '1 : power_sh[43:0];
      result.segment        <= seg_p;
    end
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##33 done)
    else $error("accepted transaction did not complete");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 33))
    else $error("result without an accepted transaction");
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.segment == SEG_NONE) |->
      (result.friction_coeff == 24'h0 && result.friction_force == 31'h0
       && result.friction_power == 44'h0))
    else $error("no-contact result not zero");
  a_power_from_force: assert property (@(posedge clk) disable iff (rst)
    (done && result.friction_force == 31'h0) |-> (result.friction_power == 44'h0))
    else $error("power without force");
`endif

endmodule
